>>> hw/rtl/flr_pkg.sv
`default_nettype none

package flr_pkg;

   // command codes
   localparam logic [2:0] CMD_APPEND = 3'd0;
   localparam logic [2:0] CMD_CLEAR  = 3'd1;
   localparam logic [2:0] CMD_COUNT  = 3'd2;
   localparam logic [2:0] CMD_GET    = 3'd3;
   localparam logic [2:0] CMD_NEWGEN = 3'd4;

   // entry levels
   localparam logic [1:0] LVL_INFO = 2'd2;

   // record kinds held per slot
   localparam logic [1:0] KIND_EMPTY = 2'd0;
   localparam logic [1:0] KIND_ENTRY = 2'd1;
   localparam logic [1:0] KIND_CLEAR = 2'd2;

   // configuration register map
   localparam int CSR_IDX_W  = 4;
   localparam int CSR_DATA_W = 6;
   localparam logic [CSR_IDX_W-1:0] CSR_SECTORS_IN_USE = 4'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_INFO_ENABLED   = 4'd1;
   localparam logic [5:0] SECTORS_RESET = 6'd25;
   localparam logic       INFO_RESET    = 1'b1;

   // entry counter, one bit wider than the reported count
   localparam int COUNT_W = 13;
   localparam logic [11:0] COUNT_SAT = 12'hFFF;

   typedef struct packed {
      logic [2:0]  command;
      logic [1:0]  level;
      logic [11:0] entry_index;
   } req_type;

   typedef struct packed {
      logic        status;
      logic        new_sector;
      logic [31:0] header_seq;
      logic [4:0]  sector;
      logic [6:0]  slot;
      logic [1:0]  level_out;
      logic [11:0] entry_count;
   } rsp_type;

   typedef enum logic [1:0] {
      RSP_IGNORED = 2'd0,
      RSP_DONE    = 2'd1,
      RSP_APPEND  = 2'd2,
      RSP_WALK    = 2'd3
   } rsp_kind_type;

   typedef struct packed {
      logic         load_req;
      logic         new_gen;
      logic         app_first;
      logic         app_next;
      logic         mod_step;
      logic         erase_step;
      logic         commit;
      logic         write_rec;
      logic         walk_init;
      logic         scan_step;
      logic         walk_mod_load;
      logic         seq_read;
      logic         sec_advance;
      logic         respond;
      rsp_kind_type rsp_kind;
   } dp_cmd_type;

   typedef struct packed {
      logic have_head;
      logic slot_full;
      logic info_enabled;
      logic mod_done;
      logic erase_last;
      logic scan_stop;
      logic scan_end;
      logic steps_exhausted;
      logic seq_break;
   } dp_sts_type;

endpackage

`default_nettype wire

>>> hw/rtl/flash_log_ring_manager_top.sv
`default_nettype none

// index and policy engine for an append-only log kept as a ring of flash sectors
// - command channel: a transaction is taken at a rising edge with start high and busy low;
//   req_data carries command, level and entry_index
// - result channel: one result per command, shown on rsp_data for exactly one cycle
//   with rsp_valid high; the receiver cannot stall, so nothing is ever held back
// - csr channel: csr_index 0 is sectors_in_use, 1 is info_enabled; csr_ready is always
//   high and writes are meant for idle periods only
// - ignored commands, count or get on an empty log and new generation give their
//   result in the cycle after acceptance; a plain append answers from the write state
// - an append that opens a sector reduces the sector number modulo the ring size, then
//   sweeps the erase over the slot store, one slot per cycle, then writes the record
// - count and get read the slot store one slot per cycle through its registered port;
//   each sector crossed passes the modulo step and the sequence check first
// - busy stays high for the whole command, so one command is in flight at a time
// - reset: log empty, ring size 25, info logging on; the slot store needs no clearing
//   because every sector is erased when it is opened

module flash_log_ring_manager_top #(
   parameter int MAX_SECTORS = 32,
   parameter int SLOTS       = 128
) (
   input  wire logic                            clock,
   input  wire logic                            reset,
   // command transactions
   input  wire logic                            start,
   output logic                                 busy,
   input  var  flr_pkg::req_type                req_data,
   // result transactions
   output logic                                 rsp_valid,
   output var  flr_pkg::rsp_type                rsp_data,
   // register writes
   input  wire logic                            csr_valid,
   output logic                                 csr_ready,
   input  wire logic [flr_pkg::CSR_IDX_W-1:0]   csr_index,
   input  wire logic [flr_pkg::CSR_DATA_W-1:0]  csr_wdata
);
   import flr_pkg::*;

   dp_cmd_type dp_cmd;
   dp_sts_type dp_sts;

   // registers are simple flops, always ready for a write
   assign csr_ready = 1'b1;

   // sequencing of appends, erase sweeps and backward walks
   flr_ctrl u_ctrl (
      .clock    (clock),
      .reset    (reset),
      .start    (start),
      .req_data (req_data),
      .sts      (dp_sts),
      .cmd      (dp_cmd),
      .busy     (busy)
   );

   // head registers, slot and sequence stores, walk counters and result register
   flr_datapath #(
      .MAX_SECTORS (MAX_SECTORS),
      .SLOTS       (SLOTS)
   ) u_datapath (
      .clock     (clock),
      .reset     (reset),
      .csr_valid (csr_valid && csr_ready),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata),
      .req_data  (req_data),
      .cmd       (dp_cmd),
      .sts       (dp_sts),
      .rsp_valid (rsp_valid),
      .rsp_data  (rsp_data)
   );

endmodule

`default_nettype wire

>>> hw/rtl/flr_datapath.sv
`default_nettype none

module flr_datapath #(
   parameter int MAX_SECTORS = 32,
   parameter int SLOTS       = 128
) (
   input  wire logic                            clock,
   input  wire logic                            reset,
   input  wire logic                            csr_valid,
   input  wire logic [flr_pkg::CSR_IDX_W-1:0]   csr_index,
   input  wire logic [flr_pkg::CSR_DATA_W-1:0]  csr_wdata,
   input  var  flr_pkg::req_type                req_data,
   input  var  flr_pkg::dp_cmd_type             cmd,
   output var  flr_pkg::dp_sts_type             sts,
   output logic                                 rsp_valid,
   output var  flr_pkg::rsp_type                rsp_data
);
   import flr_pkg::*;

   localparam int SW    = (MAX_SECTORS > 1) ? $clog2(MAX_SECTORS) : 1;
   localparam int NW    = SW + 1;
   localparam int SLW   = $clog2(SLOTS);
   localparam int NSW   = $clog2(SLOTS + 1);
   localparam int DEPTH = MAX_SECTORS * SLOTS;
   localparam int AW    = $clog2(DEPTH);
   localparam logic [NSW-1:0] SLOTS_N  = NSW'(SLOTS);
   localparam logic [NSW-1:0] SLOT_ONE = NSW'(1);
   localparam logic [NW-1:0]  MAX_N    = NW'(MAX_SECTORS);
   localparam logic [SLW-1:0] SLOT_TOP = SLW'(SLOTS - 1);

   // configuration
   logic [5:0] siu_ff, siu_in;
   logic       info_ff, info_in;

   // latched request
   req_type req_ff, req_in;

   // head tracking
   logic             have_head_ff, have_head_in;
   logic [SW-1:0]    head_ff, head_in;
   logic [31:0]      head_seq_ff, head_seq_in;
   logic [NSW-1:0]   next_slot_ff, next_slot_in;
   logic [MAX_SECTORS-1:0] owned_ff, owned_in;

   // sector arithmetic and erase sweep
   logic [NW-1:0]    x_ff, x_in;
   logic [31:0]      new_seq_ff, new_seq_in;
   logic             new_flag_ff, new_flag_in;
   logic [SLW-1:0]   erase_slot_ff, erase_slot_in;

   // backward walk
   logic [SW-1:0]      sec_ff, sec_in;
   logic [NSW-1:0]     sl_ff, sl_in;
   logic [31:0]        seq_ff, seq_in;
   logic [NW-1:0]      steps_ff, steps_in;
   logic [COUNT_W-1:0] cnt_ff, cnt_in;
   logic               pend_ff, pend_in;
   logic [SW-1:0]      found_sec_ff, found_sec_in;
   logic [SLW-1:0]     found_slot_ff, found_slot_in;
   logic [1:0]         found_lvl_ff, found_lvl_in;
   logic [NSW-1:0]     pend_slot_ff, pend_slot_in;

   // memories and their read registers
   logic [3:0]  slot_mem [DEPTH];
   logic [31:0] seq_mem  [MAX_SECTORS];
   logic [3:0]  slot_rd_ff;
   logic [31:0] seq_rd_ff;
   logic        owned_rd_ff;

   // result
   logic    rsp_valid_ff, rsp_valid_in;
   rsp_type rsp_ff, rsp_in;

   // combinational helpers
   logic [NW-1:0]      ring_n;
   logic               issue;
   logic [NSW-1:0]     issue_slot;
   logic [1:0]         pend_kind;
   logic [1:0]         pend_lvl;
   logic [COUNT_W-1:0] limit;
   logic [COUNT_W-1:0] cnt_inc;
   logic               is_get;
   logic               hit;
   logic               slot_we;
   logic [AW-1:0]      slot_waddr;
   logic [3:0]         slot_wdata;
   logic [AW-1:0]      slot_raddr;
   logic [1:0]         rec_kind;
   logic [1:0]         rec_lvl;
   logic [SW-1:0]      x_sec;

   function automatic logic [AW-1:0] slot_addr(input logic [SW-1:0] s, input logic [SLW-1:0] k);
      slot_addr = AW'(AW'(s) * AW'(SLOTS)) + AW'(k);
   endfunction

   // ring size, clamped into range
   always_comb begin
      if (siu_ff == 6'd0) begin
         ring_n = NW'(1);
      end else if (32'(siu_ff) > 32'(MAX_SECTORS)) begin
         ring_n = MAX_N;
      end else begin
         ring_n = NW'(siu_ff);
      end
   end

   assign x_sec      = x_ff[SW-1:0];
   assign is_get     = (req_ff.command == CMD_GET);
   assign limit      = COUNT_W'(req_ff.entry_index) + COUNT_W'(1);
   assign cnt_inc    = (&cnt_ff) ? cnt_ff : cnt_ff + COUNT_W'(1);
   assign issue      = cmd.scan_step && (sl_ff > SLOT_ONE);
   assign issue_slot = sl_ff - SLOT_ONE;
   assign pend_kind  = slot_rd_ff[3:2];
   assign pend_lvl   = slot_rd_ff[1:0];
   assign hit        = cmd.scan_step && pend_ff && (pend_kind == KIND_ENTRY);

   assign rec_kind = (req_ff.command == CMD_CLEAR) ? KIND_CLEAR : KIND_ENTRY;
   assign rec_lvl  = (req_ff.command == CMD_CLEAR) ? 2'd0 : req_ff.level;

   assign slot_we    = cmd.erase_step || cmd.write_rec;
   assign slot_waddr = cmd.erase_step ? slot_addr(x_sec, erase_slot_ff)
                                      : slot_addr(head_ff, next_slot_ff[SLW-1:0]);
   assign slot_wdata = cmd.erase_step ? {KIND_EMPTY, 2'd0} : {rec_kind, rec_lvl};
   assign slot_raddr = slot_addr(sec_ff, issue_slot[SLW-1:0]);

   assign sts.have_head       = have_head_ff;
   assign sts.slot_full       = (next_slot_ff >= SLOTS_N);
   assign sts.info_enabled    = info_ff;
   assign sts.mod_done        = (x_ff < ring_n);
   assign sts.erase_last      = (erase_slot_ff == SLOT_TOP);
   assign sts.scan_stop       = pend_ff && ((pend_kind == KIND_CLEAR) ||
                                ((pend_kind == KIND_ENTRY) && is_get && (cnt_inc == limit)));
   assign sts.scan_end        = !pend_ff && (sl_ff <= SLOT_ONE);
   assign sts.steps_exhausted = ((steps_ff + NW'(1)) >= ring_n);
   assign sts.seq_break       = (x_ff == NW'(head_ff)) || !owned_rd_ff ||
                                (seq_rd_ff != (seq_ff - 32'd1));

   always_comb begin
      siu_in        = siu_ff;
      info_in       = info_ff;
      req_in        = req_ff;
      have_head_in  = have_head_ff;
      head_in       = head_ff;
      head_seq_in   = head_seq_ff;
      next_slot_in  = next_slot_ff;
      owned_in      = owned_ff;
      x_in          = x_ff;
      new_seq_in    = new_seq_ff;
      new_flag_in   = new_flag_ff;
      erase_slot_in = erase_slot_ff;
      sec_in        = sec_ff;
      sl_in         = sl_ff;
      seq_in        = seq_ff;
      steps_in      = steps_ff;
      cnt_in        = cnt_ff;
      pend_in       = pend_ff;
      pend_slot_in  = pend_slot_ff;
      found_sec_in  = found_sec_ff;
      found_slot_in = found_slot_ff;
      found_lvl_in  = found_lvl_ff;

      if (csr_valid) begin
         if (csr_index == CSR_SECTORS_IN_USE) begin
            siu_in = csr_wdata;
         end else if (csr_index == CSR_INFO_ENABLED) begin
            info_in = csr_wdata[0];
         end
      end

      if (cmd.load_req) begin
         req_in      = req_data;
         new_flag_in = 1'b0;
      end

      if (cmd.new_gen) begin
         have_head_in = 1'b0;
         head_in      = '0;
         head_seq_in  = '0;
         next_slot_in = SLOT_ONE;
         owned_in     = '0;
      end

      // first sector of a log, or the one after the head
      if (cmd.app_first) begin
         x_in          = '0;
         new_seq_in    = 32'd1;
         erase_slot_in = '0;
      end
      if (cmd.app_next) begin
         x_in          = NW'(head_ff) + NW'(1);
         new_seq_in    = head_seq_ff + 32'd1;
         erase_slot_in = '0;
      end
      if (cmd.walk_mod_load) begin
         x_in     = (sec_ff == '0) ? ring_n - NW'(1) : NW'(sec_ff) - NW'(1);
         steps_in = steps_ff + NW'(1);
      end
      if (cmd.mod_step && (x_ff >= ring_n)) begin
         x_in = x_ff - ring_n;
      end

      if (cmd.erase_step) begin
         erase_slot_in = erase_slot_ff + SLW'(1);
      end

      if (cmd.commit) begin
         have_head_in    = 1'b1;
         head_in         = x_sec;
         head_seq_in     = new_seq_ff;
         next_slot_in    = SLOT_ONE;
         owned_in[x_sec] = 1'b1;
         new_flag_in     = 1'b1;
      end

      if (cmd.write_rec) begin
         next_slot_in = next_slot_ff + SLOT_ONE;
      end

      if (cmd.walk_init) begin
         sec_in   = head_ff;
         sl_in    = next_slot_ff;
         seq_in   = head_seq_ff;
         cnt_in   = '0;
         steps_in = '0;
         pend_in  = 1'b0;
      end

      // one slot read issued per cycle, evaluated the cycle after
      if (cmd.scan_step) begin
         pend_in = issue;
         if (issue) begin
            sl_in        = issue_slot;
            pend_slot_in = issue_slot;
         end
         if (hit) begin
            cnt_in        = cnt_inc;
            found_sec_in  = sec_ff;
            found_slot_in = pend_slot_ff[SLW-1:0];
            found_lvl_in  = pend_lvl;
         end
      end

      if (cmd.sec_advance) begin
         sec_in  = x_sec;
         seq_in  = seq_ff - 32'd1;
         sl_in   = SLOTS_N;
         pend_in = 1'b0;
      end
   end

   // result assembly
   always_comb begin
      rsp_valid_in = cmd.respond;
      rsp_in       = '0;
      case (cmd.rsp_kind)
         RSP_IGNORED: begin
            rsp_in.status = 1'b1;
         end
         RSP_DONE: begin
            rsp_in.status = 1'b0;
         end
         RSP_APPEND: begin
            rsp_in.new_sector = new_flag_ff;
            rsp_in.header_seq = new_flag_ff ? head_seq_ff : 32'd0;
            rsp_in.sector     = 5'(head_ff);
            rsp_in.slot       = 7'(next_slot_ff);
         end
         RSP_WALK: begin
            if (is_get) begin
               if (cnt_ff == limit) begin
                  rsp_in.sector    = 5'(found_sec_ff);
                  rsp_in.slot      = 7'(found_slot_ff);
                  rsp_in.level_out = found_lvl_ff;
               end else begin
                  rsp_in.status = 1'b1;
               end
            end else begin
               rsp_in.entry_count = (cnt_ff > COUNT_W'(COUNT_SAT)) ? COUNT_SAT : cnt_ff[11:0];
            end
         end
         default: begin
            rsp_in.status = 1'b1;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         siu_ff       <= SECTORS_RESET;
         info_ff      <= INFO_RESET;
         have_head_ff <= 1'b0;
         head_ff      <= '0;
         head_seq_ff  <= '0;
         next_slot_ff <= SLOT_ONE;
         owned_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         siu_ff       <= siu_in;
         info_ff      <= info_in;
         have_head_ff <= have_head_in;
         head_ff      <= head_in;
         head_seq_ff  <= head_seq_in;
         next_slot_ff <= next_slot_in;
         owned_ff     <= owned_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      req_ff        <= req_in;
      x_ff          <= x_in;
      new_seq_ff    <= new_seq_in;
      new_flag_ff   <= new_flag_in;
      erase_slot_ff <= erase_slot_in;
      sec_ff        <= sec_in;
      sl_ff         <= sl_in;
      seq_ff        <= seq_in;
      steps_ff      <= steps_in;
      cnt_ff        <= cnt_in;
      pend_ff       <= pend_in;
      pend_slot_ff  <= pend_slot_in;
      found_sec_ff  <= found_sec_in;
      found_slot_ff <= found_slot_in;
      found_lvl_ff  <= found_lvl_in;
      rsp_ff        <= rsp_in;
   end

   // slot store: kind and level per slot
   always_ff @(posedge clock) begin
      if (slot_we) begin
         slot_mem[slot_waddr] <= slot_wdata;
      end
      if (issue) begin
         slot_rd_ff <= slot_mem[slot_raddr];
      end
   end

   // header sequence per sector
   always_ff @(posedge clock) begin
      if (cmd.commit) begin
         seq_mem[x_sec] <= new_seq_ff;
      end
      if (cmd.seq_read) begin
         seq_rd_ff   <= seq_mem[x_sec];
         owned_rd_ff <= owned_ff[x_sec];
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_ff;

   a_rsp_ignored: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && rsp_ff.status) |-> (!rsp_ff.new_sector && rsp_ff.header_seq == 32'd0))
      else $error("ignored or missed result reports a new sector");

   a_slot_range: assert property (@(posedge clock) disable iff (reset)
      have_head_ff |-> (next_slot_ff >= SLOT_ONE && next_slot_ff <= SLOTS_N))
      else $error("next free slot out of range");

   a_write_room: assert property (@(posedge clock) disable iff (reset)
      cmd.write_rec |-> (have_head_ff && next_slot_ff < SLOTS_N))
      else $error("record written with no head or into a full sector");

   a_commit_owned: assert property (@(posedge clock) disable iff (reset)
      cmd.commit |=> (have_head_ff && owned_ff[head_ff] && next_slot_ff == SLOT_ONE))
      else $error("new sector not taken as head");

   a_walk_limit: assert property (@(posedge clock) disable iff (reset)
      (cmd.scan_step && is_get) |-> (cnt_ff < limit))
      else $error("get walk ran past its target entry");

endmodule

`default_nettype wire

>>> hw/rtl/flr_ctrl.sv
`default_nettype none

module flr_ctrl (
   input  wire logic                clock,
   input  wire logic                reset,
   input  wire logic                start,
   input  var  flr_pkg::req_type    req_data,
   input  var  flr_pkg::dp_sts_type sts,
   output var  flr_pkg::dp_cmd_type cmd,
   output logic                     busy
);
   import flr_pkg::*;

   typedef enum logic [7:0] {
      ST_IDLE     = 8'b0000_0001,
      ST_APP_MOD  = 8'b0000_0010,
      ST_ERASE    = 8'b0000_0100,
      ST_WRITE    = 8'b0000_1000,
      ST_SCAN     = 8'b0001_0000,
      ST_WALK_MOD = 8'b0010_0000,
      ST_SEQ_CHK  = 8'b0100_0000,
      ST_WALK_END = 8'b1000_0000
   } state_type;

   state_type state_ff, state_in;

   always_comb begin
      cmd      = '0;
      state_in = state_ff;
      case (state_ff)
         ST_IDLE: begin
            if (start) begin
               cmd.load_req = 1'b1;
               case (req_data.command)
                  CMD_APPEND: begin
                     if (req_data.level == LVL_INFO && !sts.info_enabled) begin
                        cmd.respond  = 1'b1;
                        cmd.rsp_kind = RSP_IGNORED;
                     end else if (!sts.have_head) begin
                        cmd.app_first = 1'b1;
                        state_in      = ST_APP_MOD;
                     end else if (sts.slot_full) begin
                        cmd.app_next = 1'b1;
                        state_in     = ST_APP_MOD;
                     end else begin
                        state_in = ST_WRITE;
                     end
                  end
                  CMD_CLEAR: begin
                     if (!sts.have_head) begin
                        cmd.respond  = 1'b1;
                        cmd.rsp_kind = RSP_IGNORED;
                     end else if (sts.slot_full) begin
                        cmd.app_next = 1'b1;
                        state_in     = ST_APP_MOD;
                     end else begin
                        state_in = ST_WRITE;
                     end
                  end
                  CMD_COUNT: begin
                     if (!sts.have_head) begin
                        cmd.respond  = 1'b1;
                        cmd.rsp_kind = RSP_DONE;
                     end else begin
                        cmd.walk_init = 1'b1;
                        state_in      = ST_SCAN;
                     end
                  end
                  CMD_GET: begin
                     if (!sts.have_head) begin
                        cmd.respond  = 1'b1;
                        cmd.rsp_kind = RSP_IGNORED;
                     end else begin
                        cmd.walk_init = 1'b1;
                        state_in      = ST_SCAN;
                     end
                  end
                  CMD_NEWGEN: begin
                     cmd.new_gen  = 1'b1;
                     cmd.respond  = 1'b1;
                     cmd.rsp_kind = RSP_DONE;
                  end
                  default: begin
                     cmd.respond  = 1'b1;
                     cmd.rsp_kind = RSP_IGNORED;
                  end
               endcase
            end
         end
         ST_APP_MOD: begin
            if (sts.mod_done) begin
               state_in = ST_ERASE;
            end else begin
               cmd.mod_step = 1'b1;
            end
         end
         ST_ERASE: begin
            cmd.erase_step = 1'b1;
            if (sts.erase_last) begin
               cmd.commit = 1'b1;
               state_in   = ST_WRITE;
            end
         end
         ST_WRITE: begin
            cmd.write_rec = 1'b1;
            cmd.respond   = 1'b1;
            cmd.rsp_kind  = RSP_APPEND;
            state_in      = ST_IDLE;
         end
         ST_SCAN: begin
            cmd.scan_step = 1'b1;
            if (sts.scan_stop) begin
               state_in = ST_WALK_END;
            end else if (sts.scan_end) begin
               if (sts.steps_exhausted) begin
                  state_in = ST_WALK_END;
               end else begin
                  cmd.walk_mod_load = 1'b1;
                  state_in          = ST_WALK_MOD;
               end
            end
         end
         ST_WALK_MOD: begin
            if (sts.mod_done) begin
               cmd.seq_read = 1'b1;
               state_in     = ST_SEQ_CHK;
            end else begin
               cmd.mod_step = 1'b1;
            end
         end
         ST_SEQ_CHK: begin
            if (sts.seq_break) begin
               state_in = ST_WALK_END;
            end else begin
               cmd.sec_advance = 1'b1;
               state_in        = ST_SCAN;
            end
         end
         ST_WALK_END: begin
            cmd.respond  = 1'b1;
            cmd.rsp_kind = RSP_WALK;
            state_in     = ST_IDLE;
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   assign busy = (state_ff != ST_IDLE);

endmodule

`default_nettype wire

>>> sim/tb_top.sv
`timescale 1ns / 100ps

module tb_top;

   import flr_pkg::*;

   // geometry of the ring, as built by default
   localparam int NSEC  = 32;
   localparam int NSLOT = 128;

   // result status codes
   localparam logic ST_DONE = 1'b0;
   localparam logic ST_MISS = 1'b1;

   // command codes with no meaning, and levels the package leaves unnamed
   localparam logic [2:0] CMD_RSVD5 = 3'd5;
   localparam logic [2:0] CMD_RSVD6 = 3'd6;
   localparam logic [2:0] CMD_RSVD7 = 3'd7;
   localparam logic [1:0] LVL_ERROR = 2'd0;
   localparam logic [1:0] LVL_WARN  = 2'd1;
   localparam logic [1:0] LVL_USER  = 2'd3;

   // register index that maps to nothing
   localparam logic [CSR_IDX_W-1:0] CSR_UNMAPPED = 4'hF;

   // run limits: worst case is a walk over a full ring for every item
   localparam int RUN_LIMIT   = 10_000_000;
   localparam int DRAIN_LIMIT = 20_000;
   localparam int SETTLE      = 8;

   // random phases: ring size written, info logging, sender idle percentage
   localparam int NPHASE      = 5;
   localparam int PHASE_ITEMS = 23;
   localparam logic [5:0] PHASE_RING [NPHASE] = '{6'd0, 6'd4, 6'd63, 6'd2, 6'd32};
   localparam logic       PHASE_INFO [NPHASE] = '{1'b1, 1'b0, 1'b1, 1'b0, 1'b1};
   localparam int         PHASE_IDLE [NPHASE] = '{0, 75, 0, 18, 75};

   localparam rsp_type NOTHING = '0;
   localparam rsp_type MISSED  = '{ST_MISS, 1'b0, 32'd0, 5'd0, 7'd0, LVL_ERROR, 12'd0};

   // directed table: a pinned row carries its own expected result
   typedef enum logic [1:0] {
      ROW_PRED = 2'd0,
      ROW_PIN  = 2'd1,
      ROW_CSR  = 2'd2
   } row_kind_type;

   typedef struct packed {
      row_kind_type           kind;
      req_type                req;
      rsp_type                want;
      logic [CSR_IDX_W-1:0]   reg_sel;
      logic [CSR_DATA_W-1:0]  reg_val;
   } plan_row_type;

   localparam int PLAN_LEN = 30;
   localparam plan_row_type PLAN [PLAN_LEN] = '{
      // empty log: walks find nothing, clear and unknown commands are ignored
      '{ROW_PIN, '{CMD_COUNT, LVL_ERROR, 12'd0}, NOTHING, CSR_UNMAPPED, 6'd0},
      '{ROW_PIN, '{CMD_GET, LVL_ERROR, 12'd0}, MISSED, CSR_UNMAPPED, 6'd0},
      '{ROW_PIN, '{CMD_CLEAR, LVL_USER, 12'd0}, MISSED, CSR_UNMAPPED, 6'd0},
      '{ROW_PIN, '{CMD_RSVD5, LVL_ERROR, 12'd0}, MISSED, CSR_UNMAPPED, 6'd0},
      '{ROW_PIN, '{CMD_RSVD6, LVL_USER, 12'hFFF}, MISSED, CSR_UNMAPPED, 6'd0},
      '{ROW_PIN, '{CMD_RSVD7, LVL_WARN, 12'h555}, MISSED, CSR_UNMAPPED, 6'd0},
      // first append heads sector 0 with sequence 1
      '{ROW_PIN, '{CMD_APPEND, LVL_ERROR, 12'd0},
        '{ST_DONE, 1'b1, 32'd1, 5'd0, 7'd1, LVL_ERROR, 12'd0}, CSR_UNMAPPED, 6'd0},
      '{ROW_PIN, '{CMD_APPEND, LVL_WARN, 12'hFFF},
        '{ST_DONE, 1'b0, 32'd0, 5'd0, 7'd2, LVL_ERROR, 12'd0}, CSR_UNMAPPED, 6'd0},
      '{ROW_PIN, '{CMD_APPEND, LVL_INFO, 12'd0},
        '{ST_DONE, 1'b0, 32'd0, 5'd0, 7'd3, LVL_ERROR, 12'd0}, CSR_UNMAPPED, 6'd0},
      '{ROW_PIN, '{CMD_APPEND, LVL_USER, 12'd0},
        '{ST_DONE, 1'b0, 32'd0, 5'd0, 7'd4, LVL_ERROR, 12'd0}, CSR_UNMAPPED, 6'd0},
      '{ROW_PIN, '{CMD_COUNT, LVL_ERROR, 12'd0},
        '{ST_DONE, 1'b0, 32'd0, 5'd0, 7'd0, LVL_ERROR, 12'd4}, CSR_UNMAPPED, 6'd0},
      // newest and oldest entries, then one past the end and the far extreme
      '{ROW_PIN, '{CMD_GET, LVL_ERROR, 12'd0},
        '{ST_DONE, 1'b0, 32'd0, 5'd0, 7'd4, LVL_USER, 12'd0}, CSR_UNMAPPED, 6'd0},
      '{ROW_PIN, '{CMD_GET, LVL_ERROR, 12'd3},
        '{ST_DONE, 1'b0, 32'd0, 5'd0, 7'd1, LVL_ERROR, 12'd0}, CSR_UNMAPPED, 6'd0},
      '{ROW_PIN, '{CMD_GET, LVL_ERROR, 12'd4}, MISSED, CSR_UNMAPPED, 6'd0},
      '{ROW_PIN, '{CMD_GET, LVL_USER, 12'hFFF}, MISSED, CSR_UNMAPPED, 6'd0},
      // clear marker hides everything older, its level is dropped
      '{ROW_PIN, '{CMD_CLEAR, LVL_USER, 12'd0},
        '{ST_DONE, 1'b0, 32'd0, 5'd0, 7'd5, LVL_ERROR, 12'd0}, CSR_UNMAPPED, 6'd0},
      '{ROW_PIN, '{CMD_COUNT, LVL_ERROR, 12'd0}, NOTHING, CSR_UNMAPPED, 6'd0},
      '{ROW_PIN, '{CMD_GET, LVL_ERROR, 12'd0}, MISSED, CSR_UNMAPPED, 6'd0},
      '{ROW_PIN, '{CMD_APPEND, LVL_INFO, 12'd0},
        '{ST_DONE, 1'b0, 32'd0, 5'd0, 7'd6, LVL_ERROR, 12'd0}, CSR_UNMAPPED, 6'd0},
      '{ROW_PIN, '{CMD_COUNT, LVL_ERROR, 12'd0},
        '{ST_DONE, 1'b0, 32'd0, 5'd0, 7'd0, LVL_ERROR, 12'd1}, CSR_UNMAPPED, 6'd0},
      '{ROW_PRED, '{CMD_GET, LVL_WARN, 12'd0}, NOTHING, CSR_UNMAPPED, 6'd0},
      // info logging off, upper data bits set: info entry dropped, others still land
      '{ROW_CSR, '{CMD_COUNT, LVL_ERROR, 12'd0}, NOTHING, CSR_INFO_ENABLED, 6'b111110},
      '{ROW_PIN, '{CMD_APPEND, LVL_INFO, 12'd0}, MISSED, CSR_UNMAPPED, 6'd0},
      '{ROW_PRED, '{CMD_APPEND, LVL_WARN, 12'd0}, NOTHING, CSR_UNMAPPED, 6'd0},
      '{ROW_CSR, '{CMD_COUNT, LVL_ERROR, 12'd0}, NOTHING, CSR_INFO_ENABLED, 6'b000001},
      // write to an index with no register behind it
      '{ROW_CSR, '{CMD_COUNT, LVL_ERROR, 12'd0}, NOTHING, CSR_UNMAPPED, 6'h3F},
      // new generation empties the log and restarts the sequence
      '{ROW_PIN, '{CMD_NEWGEN, LVL_USER, 12'hFFF}, NOTHING, CSR_UNMAPPED, 6'd0},
      '{ROW_PIN, '{CMD_COUNT, LVL_ERROR, 12'd0}, NOTHING, CSR_UNMAPPED, 6'd0},
      '{ROW_PIN, '{CMD_APPEND, LVL_USER, 12'd0},
        '{ST_DONE, 1'b1, 32'd1, 5'd0, 7'd1, LVL_ERROR, 12'd0}, CSR_UNMAPPED, 6'd0},
      '{ROW_PRED, '{CMD_GET, LVL_ERROR, 12'd0}, NOTHING, CSR_UNMAPPED, 6'd0}
   };

   // clock, reset and block inputs, all known from time zero
   logic                   clock     = 1'b0;
   logic                   reset     = 1'b1;
   logic                   start     = 1'b0;
   req_type                req_data  = '0;
   logic                   csr_valid = 1'b0;
   logic [CSR_IDX_W-1:0]   csr_index = '0;
   logic [CSR_DATA_W-1:0]  csr_wdata = '0;
   logic                   busy;
   logic                   rsp_valid;
   rsp_type                rsp_data;
   logic                   csr_ready;

   // pinned expectation travels with the command it belongs to
   logic    pin_on  = 1'b0;
   rsp_type pin_rsp = '0;

   // results still owed by the block, oldest first
   rsp_type results_due [$];
   int      errors = 0;
   int      cycles = 0;

   // shadow of the log: configuration, head pointer and per-slot records
   logic [5:0]  ring_setting = SECTORS_RESET;
   logic        info_on      = INFO_RESET;
   logic        log_live     = 1'b0;
   int unsigned top_sector   = 0;
   logic [31:0] top_seq      = 32'd0;
   int unsigned fill_slot    = 1;
   logic [1:0]  rec_kind  [NSEC*NSLOT] = '{default: KIND_EMPTY};
   logic [1:0]  rec_level [NSEC*NSLOT] = '{default: 2'd0};
   logic [31:0] sector_seq  [NSEC] = '{default: 32'd0};
   logic        sector_mine [NSEC] = '{default: 1'b0};

   always #5 clock = ~clock;

   flash_log_ring_manager_top uut (
      .clock     (clock),
      .reset     (reset),
      .start     (start),
      .busy      (busy),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_data  (rsp_data),
      .csr_valid (csr_valid),
      .csr_ready (csr_ready),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata)
   );

   // ring size as the block uses it: zero acts as one, the top clamps
   function automatic int unsigned ring_span();
      int unsigned n;
      n = 32'(ring_setting);
      if (n < 1) n = 1;
      if (n > NSEC) n = NSEC;
      return n;
   endfunction

   // erase a sector and make it the head
   function automatic void open_sector(input int unsigned sec, input logic [31:0] seq);
      for (int s = 0; s < NSLOT; s++) begin
         rec_kind[sec*NSLOT + s]  = KIND_EMPTY;
         rec_level[sec*NSLOT + s] = 2'd0;
      end
      sector_seq[sec]  = seq;
      sector_mine[sec] = 1'b1;
      top_sector = sec;
      top_seq    = seq;
      fill_slot  = 1;
      log_live   = 1'b1;
   endfunction

   // place one record, heading a fresh sector when the current one is full
   function automatic void add_record(input logic [1:0] kind, input logic [1:0] lvl,
                                      inout rsp_type o);
      int unsigned n;
      n = ring_span();
      if (!log_live) begin
         open_sector(0, 32'd1);
         o.new_sector = 1'b1;
         o.header_seq = top_seq;
      end else if (fill_slot >= NSLOT) begin
         open_sector((top_sector + 1) % n, top_seq + 32'd1);
         o.new_sector = 1'b1;
         o.header_seq = top_seq;
      end
      rec_kind[top_sector*NSLOT + fill_slot]  = kind;
      rec_level[top_sector*NSLOT + fill_slot] = lvl;
      o.sector = top_sector[4:0];
      o.slot   = fill_slot[6:0];
      fill_slot++;
   endfunction

   // count entries newest first, stopping at a marker, the head, a foreign sector,
   // a sequence break or after hit entries; reports where the last one counted sits
   function automatic int unsigned walk_entries(input int unsigned hit,
                                                output int unsigned fsec,
                                                output int unsigned fslot);
      int unsigned n, sec, sl, cnt, steps;
      logic [31:0] seq;
      logic [1:0]  k;
      n     = ring_span();
      sec   = top_sector;
      sl    = fill_slot;
      seq   = top_seq;
      cnt   = 0;
      steps = 0;
      fsec  = 0;
      fslot = 0;
      if (!log_live) return 0;
      if (sl > NSLOT) sl = NSLOT;
      while (1'b1) begin
         while (sl > 1) begin
            sl--;
            k = rec_kind[sec*NSLOT + sl];
            if (k == KIND_CLEAR) return cnt;
            if (k == KIND_ENTRY) begin
               cnt++;
               fsec  = sec;
               fslot = sl;
               if (cnt == hit) return cnt;
            end
         end
         steps++;
         if (steps >= n) return cnt;
         sec = (sec + n - 1) % n;
         if (sec == top_sector || !sector_mine[sec] || sector_seq[sec] != seq - 32'd1)
            return cnt;
         seq--;
         sl = NSLOT;
      end
      return cnt;
   endfunction

   // expected result of one command, updating the shadow log
   function automatic rsp_type log_outcome(input req_type r);
      rsp_type     o;
      int unsigned cnt, fs, fl;
      o = '0;
      case (r.command)
         CMD_APPEND: begin
            if (r.level == LVL_INFO && !info_on) o.status = ST_MISS;
            else add_record(KIND_ENTRY, r.level, o);
         end
         CMD_CLEAR: begin
            if (!log_live) o.status = ST_MISS;
            else add_record(KIND_CLEAR, LVL_ERROR, o);
         end
         CMD_COUNT: begin
            cnt = walk_entries(32'hFFFF_FFFF, fs, fl);
            o.entry_count = (cnt > 4095) ? COUNT_SAT : cnt[11:0];
         end
         CMD_GET: begin
            cnt = walk_entries(32'(r.entry_index) + 32'd1, fs, fl);
            if (cnt == 32'(r.entry_index) + 32'd1) begin
               o.sector    = fs[4:0];
               o.slot      = fl[6:0];
               o.level_out = rec_level[fs*NSLOT + fl];
            end else begin
               o.status = ST_MISS;
            end
         end
         CMD_NEWGEN: begin
            log_live   = 1'b0;
            top_sector = 0;
            top_seq    = 32'd0;
            fill_slot  = 1;
            foreach (sector_mine[i]) sector_mine[i] = 1'b0;
         end
         default: o.status = ST_MISS;
      endcase
      return o;
   endfunction

   function automatic void check_field(input string what, input logic [31:0] want,
                                       input logic [31:0] got);
      if (want !== got) begin
         errors++;
         $display("%0t ns: %s mismatch, expected %0d, actual %0d", $time, what, want, got);
      end
   endfunction

   // random command: mostly appends so that sectors fill and the ring turns over
   function automatic req_type pick_command();
      req_type     r;
      int unsigned roll;
      r.level       = 2'($urandom_range(0, 3));
      r.entry_index = 12'($urandom_range(0, 4095));
      roll          = $urandom_range(0, 999);
      if (roll < 780) begin
         r.command = CMD_APPEND;
      end else if (roll < 810) begin
         r.command = CMD_CLEAR;
      end else if (roll < 860) begin
         r.command = CMD_COUNT;
      end else if (roll < 950) begin
         r.command = CMD_GET;
         case ($urandom_range(0, 3))
            0, 1: r.entry_index = 12'($urandom_range(0, 15));
            2: r.entry_index = 12'($urandom_range(0, 300));
            default: r.entry_index = 12'($urandom_range(0, 4095));
         endcase
      end else if (roll < 953) begin
         r.command = CMD_NEWGEN;
      end else begin
         case ($urandom_range(0, 2))
            0: r.command = CMD_RSVD5;
            1: r.command = CMD_RSVD6;
            default: r.command = CMD_RSVD7;
         endcase
      end
      return r;
   endfunction

   // present one command and hold it until the block takes the transaction
   task automatic drive_cmd(input req_type r, input logic pinned, input rsp_type want);
      req_data <= r;
      pin_on   <= pinned;
      pin_rsp  <= want;
      start    <= 1'b1;
      do @(posedge clock); while (busy);
   endtask

   // register write, only once the block has gone quiet
   task automatic write_reg(input logic [CSR_IDX_W-1:0] sel,
                            input logic [CSR_DATA_W-1:0] val);
      start <= 1'b0;
      do @(posedge clock); while (results_due.size() != 0 || busy);
      csr_index <= sel;
      csr_wdata <= val;
      csr_valid <= 1'b1;
      do @(posedge clock); while (!csr_ready);
      csr_valid <= 1'b0;
   endtask

   // one place that watches the edges: results are checked before a new command is
   // predicted, so a push and a pop in the same cycle always land in order
   always @(posedge clock) begin : watch
      rsp_type awaited;
      rsp_type predicted;
      if (!reset) begin
         if (rsp_valid) begin
            if (results_due.size() == 0) begin
               errors++;
               $display("%0t ns: result with nothing awaited, expected none, actual %h",
                        $time, rsp_data);
            end else begin
               awaited = results_due.pop_front();
               check_field("status", 32'(awaited.status), 32'(rsp_data.status));
               check_field("new_sector", 32'(awaited.new_sector), 32'(rsp_data.new_sector));
               check_field("header_seq", awaited.header_seq, rsp_data.header_seq);
               check_field("sector", 32'(awaited.sector), 32'(rsp_data.sector));
               check_field("slot", 32'(awaited.slot), 32'(rsp_data.slot));
               check_field("level_out", 32'(awaited.level_out), 32'(rsp_data.level_out));
               check_field("entry_count", 32'(awaited.entry_count),
                           32'(rsp_data.entry_count));
            end
         end
         if (csr_valid && csr_ready) begin
            case (csr_index)
               CSR_SECTORS_IN_USE: ring_setting = csr_wdata;
               CSR_INFO_ENABLED:   info_on      = csr_wdata[0];
               default: ;
            endcase
         end
         if (start && !busy) begin
            predicted = log_outcome(req_data);
            results_due.push_back(pin_on ? pin_rsp : predicted);
         end
      end
   end

   // hard stop in case the block hangs
   always @(posedge clock) begin
      cycles <= cycles + 1;
      if (cycles >= RUN_LIMIT) begin
         $display("flash_log_ring_manager_top test failed");
         $finish;
      end
   end

   initial begin : main
      logic [4:0] pad;
      int         drain;
      repeat (3) @(posedge clock);
      reset <= 1'b0;

      // directed table
      for (int i = 0; i < PLAN_LEN; i++) begin
         case (PLAN[i].kind)
            ROW_CSR: write_reg(PLAN[i].reg_sel, PLAN[i].reg_val);
            ROW_PIN: drive_cmd(PLAN[i].req, 1'b1, PLAN[i].want);
            default: drive_cmd(PLAN[i].req, 1'b0, NOTHING);
         endcase
      end

      // random phases; the log carries over so ring size changes hit a live log
      for (int p = 0; p < NPHASE; p++) begin
         pad = 5'($urandom);
         write_reg(CSR_SECTORS_IN_USE, PHASE_RING[p]);
         write_reg(CSR_INFO_ENABLED, {pad, PHASE_INFO[p]});
         for (int k = 0; k < PHASE_ITEMS; k++) begin
            if (k == PHASE_ITEMS / 3) begin
               // hold off until every owed result is back
               start <= 1'b0;
               do @(posedge clock); while (results_due.size() != 0);
            end else if ($urandom_range(0, 99) < PHASE_IDLE[p]) begin
               start <= 1'b0;
               do @(posedge clock); while ($urandom_range(0, 99) < PHASE_IDLE[p]);
            end
            drive_cmd(pick_command(), 1'b0, NOTHING);
         end
      end

      // drain, then leave room for any stray result
      start <= 1'b0;
      drain = 0;
      while (results_due.size() != 0 && drain < DRAIN_LIMIT) begin
         @(posedge clock);
         drain++;
      end
      if (results_due.size() != 0) begin
         errors++;
         $display("%0t ns: %0d results never arrived", $time, results_due.size());
      end
      repeat (SETTLE) @(posedge clock);

      if (errors == 0) begin
         $display("flash_log_ring_manager_top test passed");
      end else begin
         $display("flash_log_ring_manager_top test failed");
      end
      $finish;
   end

endmodule
